/* hw/rtl/dads_pkg.sv */
// Shared types and constants for the decimating converter average scaler.
`default_nettype none

package dads_pkg;

	// Converter sample and scan geometry.
	localparam int SAMPLE_W     = 10;
	localparam int SUBSAMPLES   = 4;
	localparam int SUBSAMPLE_SH = $clog2(SUBSAMPLES);
	localparam int TOTAL_W      = SAMPLE_W + SUBSAMPLE_SH;

	// Channels: current and voltage.
	localparam int CHANNELS = 2;
	localparam int CH_W     = 1;
	localparam logic [CH_W-1:0] CH_CURRENT = 1'b0;
	localparam logic [CH_W-1:0] CH_VOLTAGE = 1'b1;

	// Result widths.
	localparam int AVG_W    = 10;
	localparam int SCALED_W = 20;

	// Configuration registers.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE = 2'd1;
	localparam logic [CFG_DATA_W-1:0] CURRENT_SCALE_RST = 16'd532;
	localparam logic [CFG_DATA_W-1:0] VOLTAGE_SCALE_RST = 16'd3488;

	// Divide by 100 as multiply by reciprocal: exact for products below 2^26.
	localparam int PROD_W       = AVG_W + CFG_DATA_W;
	localparam int DIV100_SH    = 33;
	localparam int DIV100_M_W   = 27;
	localparam logic [DIV100_M_W-1:0] DIV100_M = 27'd85899346;

	typedef struct packed {
		logic [CH_W-1:0]     mode;
		logic [SAMPLE_W-1:0] sample_a;
		logic [SAMPLE_W-1:0] sample_b;
		logic [SAMPLE_W-1:0] sample_c;
		logic [SAMPLE_W-1:0] sample_d;
	} scan_t;

	typedef struct packed {
		logic [CH_W-1:0]     result_channel;
		logic [AVG_W-1:0]    block_average;
		logic [SCALED_W-1:0] scaled_value;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/decimating_adc_average_scaler.sv */
// Top level: per-channel boxcar decimator with scaled block average output.
// A full block is emitted by the next scan of its channel. Throughput: one scan per cycle;
// the channel state memory is read at accept and written back as the scan leaves the update
// stage, with a forwarding register for back-to-back scans of one channel. scan_ready drops
// only while a completed block waits in the update stage, all four result stages are full
// and result_ready is low. Reset clears the valid bits of the state memory (entries read as
// zero), all stage valids and restores the scale registers to 532 and 3488.
`default_nettype none

module decimating_adc_average_scaler #(
	parameter int BLOCK_LEN = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          scan_valid,
	output logic                         scan_ready,
	input  wire dads_pkg::scan_t         scan,
	output logic                         result_valid,
	input  wire                          result_ready,
	output dads_pkg::result_t            result,
	input  wire                          cfg_write,
	input  wire [dads_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [dads_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dads_pkg::*;

	// Running sum holds up to BLOCK_LEN scan averages.
	localparam int SUM_W  = $clog2(BLOCK_LEN * ((1 << AVG_W) - 1) + 1);
	localparam int CNT_W  = $clog2(BLOCK_LEN + 1);
	// sum / BLOCK_LEN as a multiply by a rounded-up reciprocal, exact over SUM_W bits.
	localparam int AVG_SH  = SUM_W + $clog2(BLOCK_LEN);
	localparam int AVG_M_W = SUM_W + 1;
	localparam longint AVG_M_L = ((64'd1 << AVG_SH) + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam logic [AVG_M_W-1:0] AVG_M = AVG_M_W'(AVG_M_L);

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
	} entry_t;

	// ---------------- configuration ----------------
	logic [CFG_DATA_W-1:0] current_scale_q;
	logic [CFG_DATA_W-1:0] voltage_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_scale_q <= CURRENT_SCALE_RST;
			voltage_scale_q <= VOLTAGE_SCALE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CURRENT_SCALE: current_scale_q <= cfg_data;
				REG_VOLTAGE_SCALE: voltage_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- handshake / stage advance ----------------
	logic scan_acc;
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic emit_s1, s1_leave;
	logic out_adv, s4_ready, s3_ready, s2_ready;

	// Bubbles collapse: a stage loads whenever it is empty or its content moves on.
	assign out_adv  = !out_valid_q || result_ready;
	assign s4_ready = !v_s4 || out_adv;
	assign s3_ready = !v_s3 || s4_ready;
	assign s2_ready = !v_s2 || s3_ready;
	// A scan that closes no block never needs the result path.
	assign s1_leave   = v_s1 && (!emit_s1 || s2_ready);
	assign scan_ready = !v_s1 || s1_leave;
	assign scan_acc   = scan_valid && scan_ready;

	// ---------------- stage 0: scan average, state read ----------------
	logic [TOTAL_W-1:0] total;
	logic [AVG_W-1:0]   scan_avg;

	always_comb begin
		total = TOTAL_W'(scan.sample_a) + TOTAL_W'(scan.sample_b)
		      + TOTAL_W'(scan.sample_c) + TOTAL_W'(scan.sample_d);
		scan_avg = AVG_W'(total >> SUBSAMPLE_SH);
	end

	// ---------------- channel state memory ----------------
	entry_t              state_mem_q [CHANNELS];
	logic [CHANNELS-1:0] mem_vld_q;
	entry_t              rd_s1;
	entry_t              new_ent;
	logic [CH_W-1:0]     ch_s1;
	logic [AVG_W-1:0]    avg_s1;
	logic                rvld_s1;
	logic                fwd_s1;
	entry_t              byp_s1;

	// Read at accept, write back as the scan leaves the update stage.
	always_ff @(posedge clk) begin
		if (s1_leave) begin
			state_mem_q[ch_s1] <= new_ent;
		end
		if (scan_acc) begin
			rd_s1 <= state_mem_q[scan.mode];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= '0;
			rvld_s1   <= 1'b0;
			fwd_s1    <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			if (s1_leave) begin
				mem_vld_q[ch_s1] <= 1'b1;
			end
			if (scan_acc) begin
				rvld_s1 <= mem_vld_q[scan.mode];
				// Same-edge write to the entry being read: take the new value instead.
				fwd_s1  <= s1_leave && (ch_s1 == scan.mode);
			end
			if (scan_ready) begin
				v_s1 <= scan_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_acc) begin
			ch_s1  <= scan.mode;
			avg_s1 <= scan_avg;
			byp_s1 <= new_ent;
		end
	end

	// ---------------- stage 1: read-modify-write ----------------
	entry_t cur_ent;

	always_comb begin
		if (fwd_s1) begin
			cur_ent = byp_s1;
		end else if (rvld_s1) begin
			cur_ent = rd_s1;
		end else begin
			cur_ent = '0;
		end
		emit_s1 = cur_ent.count >= CNT_W'(BLOCK_LEN);
		// Close the block: restart with this scan as the first of the next one.
		if (emit_s1) begin
			new_ent.count = CNT_W'(1);
			new_ent.sum   = SUM_W'(avg_s1);
		end else begin
			new_ent.count = CNT_W'(cur_ent.count + 1'b1);
			new_ent.sum   = SUM_W'(cur_ent.sum + SUM_W'(avg_s1));
		end
	end

	// ---------------- stage 2: block sum ----------------
	logic [CH_W-1:0]          ch_s2;
	logic [SUM_W-1:0]         sum_s2;
	logic [SUM_W+AVG_M_W-1:0] avg_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ready)
				v_s2 <= s1_leave && emit_s1;
			if (s3_ready)
				v_s3 <= v_s2;
			if (s4_ready)
				v_s4 <= v_s3;
			if (out_adv)
				out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			ch_s2  <= ch_s1;
			sum_s2 <= cur_ent.sum;
		end
	end

	assign avg_prod = (SUM_W+AVG_M_W)'(sum_s2) * (SUM_W+AVG_M_W)'(AVG_M);

	// ---------------- stage 3: block average, scale multiply ----------------
	logic [CH_W-1:0]       ch_s3;
	logic [AVG_W-1:0]      avg_s3;
	logic [CFG_DATA_W-1:0] scale_s3;

	always_ff @(posedge clk) begin
		if (s3_ready) begin
			ch_s3  <= ch_s2;
			avg_s3 <= avg_prod[AVG_SH +: AVG_W];
		end
	end

	assign scale_s3 = (ch_s3 == CH_VOLTAGE) ? voltage_scale_q : current_scale_q;

	// ---------------- stage 4: divide by 100 ----------------
	logic [CH_W-1:0]             ch_s4;
	logic [AVG_W-1:0]            avg_s4;
	logic [PROD_W-1:0]           prod_s4;
	logic [PROD_W+DIV100_M_W-1:0] div_prod;

	always_ff @(posedge clk) begin
		if (s4_ready) begin
			ch_s4   <= ch_s3;
			avg_s4  <= avg_s3;
			prod_s4 <= PROD_W'(avg_s3) * PROD_W'(scale_s3);
		end
	end

	assign div_prod = (PROD_W+DIV100_M_W)'(prod_s4) * (PROD_W+DIV100_M_W)'(DIV100_M);

	// ---------------- output register ----------------
	result_t result_q;

	always_ff @(posedge clk) begin
		if (out_adv) begin
			result_q.result_channel <= ch_s4;
			result_q.block_average  <= avg_s4;
			result_q.scaled_value   <= div_prod[DIV100_SH +: SCALED_W];
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	// ---------------- assertions ----------------
	// Count never runs past the block length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (cur_ent.count <= CNT_W'(BLOCK_LEN)))
		else $error("channel count above block length");

	// Intake stalls only behind a completed block that cannot move on.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_ready |-> (v_s1 && emit_s1 && !s2_ready))
		else $error("scan_ready low without a blocked result");

	// A completed block leaving the update stage enters the result path.
	a_emit_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_leave && emit_s1) |=> (v_s2 && (ch_s2 == $past(ch_s1))))
		else $error("completed block lost on its way to the result path");

endmodule

`default_nettype wire
